// File: rtl/srf_pkg.sv
// Shared types and codes for the searchable record FIFO.
// No dependencies; every other file of the block imports this package.
package srf_pkg;

  localparam int DEFAULT_QUEUE_DEPTH = 32;
  localparam int FILL_W = 6;
  localparam int ACT_W  = 3;
  localparam int STAT_W = 2;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_ENQ        = 3'd0;
  localparam logic [ACT_W-1:0] ACT_DEQ        = 3'd1;
  localparam logic [ACT_W-1:0] ACT_FIND_CODE  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_FIND_HOURS = 3'd3;
  localparam logic [ACT_W-1:0] ACT_LIST       = 3'd4;
  localparam logic [ACT_W-1:0] ACT_CLEAR      = 3'd5;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOMATCH = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic signed [31:0] code;
    logic [31:0]        hours;
    logic [31:0]        tag;
  } rec_t;

  typedef struct packed {
    rec_t              rec;
    logic [STAT_W-1:0] status;
    logic              last;
    logic              is_empty;
    logic [FILL_W-1:0] fill_count;
  } res_t;

  typedef struct packed {
    logic valid;
    res_t res;
  } push_t;

endpackage

// File: rtl/srf_if.sv
// Channel interfaces of the searchable record FIFO: action beats in, result beats out.
// Depends on srf_pkg for field widths.
interface srf_in_if import srf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ACT_W-1:0]   action;
  logic signed [31:0] entry_code;
  logic [31:0]        entry_hours;
  logic [31:0]        entry_tag;

  modport source (output valid, action, entry_code, entry_hours, entry_tag, input ready);
  modport sink   (input valid, action, entry_code, entry_hours, entry_tag, output ready);
endinterface

interface srf_out_if import srf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic signed [31:0] out_code;
  logic [31:0]        out_hours;
  logic [31:0]        out_tag;
  logic [STAT_W-1:0]  status;
  logic               last;
  logic               is_empty;
  logic [FILL_W-1:0]  fill_count;

  modport source (output valid, out_code, out_hours, out_tag, status, last, is_empty,
                  fill_count, input ready);
  modport sink   (input valid, out_code, out_hours, out_tag, status, last, is_empty,
                  fill_count, output ready);
endinterface

// File: rtl/srf_mem.sv
// Record store: one write port, one read port with registered read data.
// Depends on srf_pkg for the record type.
module srf_mem import srf_pkg::*; #(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH,
  localparam int IDX_W = $clog2(QUEUE_DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  rec_t             wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output rec_t             rd_data
);

  rec_t mem [QUEUE_DEPTH];
  rec_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds until the next read so a stalled compare keeps its operand
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/srf_obuf.sv
// Two-entry result buffer between the sequencer and the result channel.
// Depends on srf_pkg and the srf_out_if interface.
module srf_obuf import srf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  push_t     push,
  output logic      push_room,
  srf_out_if.source out_ch
);

  res_t       ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       pop;
  res_t       head;

  assign pop       = out_ch.valid && out_ch.ready;
  assign push_room = (cnt_r != 2'd2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push.valid) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push.valid} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      ent_r[wp_r] <= push.res;
    end
  end

  assign head              = ent_r[rp_r];
  assign out_ch.valid      = (cnt_r != 2'd0);
  assign out_ch.out_code   = head.rec.code;
  assign out_ch.out_hours  = head.rec.hours;
  assign out_ch.out_tag    = head.rec.tag;
  assign out_ch.status     = head.status;
  assign out_ch.last       = head.last;
  assign out_ch.is_empty   = head.is_empty;
  assign out_ch.fill_count = head.fill_count;

endmodule

// File: rtl/srf_ctrl.sv
// Sequencer: ring pointers, fill count, and the head-to-tail walk for searches and listing.
// Depends on srf_pkg, the srf_in_if interface, and drives srf_mem and srf_obuf.
module srf_ctrl import srf_pkg::*; #(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH,
  localparam int IDX_W = $clog2(QUEUE_DEPTH),
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  srf_in_if.sink           in_ch,
  output logic             wr_en,
  output logic [IDX_W-1:0] wr_addr,
  output rec_t             wr_data,
  output logic             rd_en,
  output logic [IDX_W-1:0] rd_addr,
  input  rec_t             rd_data,
  output push_t            push,
  input  logic             push_room
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEQ  = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  logic [2:0]         state_r, state_nxt;
  logic [IDX_W-1:0]   head_r, head_nxt;
  logic [IDX_W-1:0]   tail_r, tail_nxt;
  logic [CNT_W-1:0]   held_r, held_nxt;
  logic [IDX_W-1:0]   walk_r, walk_nxt;
  logic [CNT_W-1:0]   rem_r, rem_nxt;
  logic [ACT_W-1:0]   act_r, act_nxt;
  logic signed [31:0] key_code_r, key_code_nxt;
  logic [31:0]        key_hours_r, key_hours_nxt;
  rec_t               pend_r, pend_nxt;
  logic               pend_v_r, pend_v_nxt;

  logic               accept;
  logic               hit;
  logic               need_push;
  logic               go;
  logic [IDX_W-1:0]   walk_next_idx;
  rec_t               in_rec;

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
    ring_next = (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  assign in_ch.ready = (state_r == S_IDLE) && push_room;
  assign accept      = in_ch.valid && in_ch.ready;

  assign in_rec.code  = in_ch.entry_code;
  assign in_rec.hours = in_ch.entry_hours;
  assign in_rec.tag   = in_ch.entry_tag;

  always_comb begin
    case (act_r)
      ACT_FIND_CODE:  hit = (rd_data.code == key_code_r);
      ACT_FIND_HOURS: hit = (rd_data.hours == key_hours_r);
      default:        hit = 1'b1;
    endcase
  end

  // Only a second hit forces out the held one; otherwise the walk never waits
  assign need_push     = hit && pend_v_r;
  assign go            = !need_push || push_room;
  assign walk_next_idx = ring_next(walk_r);

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    held_nxt      = held_r;
    walk_nxt      = walk_r;
    rem_nxt       = rem_r;
    act_nxt       = act_r;
    key_code_nxt  = key_code_r;
    key_hours_nxt = key_hours_r;
    pend_nxt      = pend_r;
    pend_v_nxt    = pend_v_r;
    wr_en         = 1'b0;
    wr_addr       = tail_r;
    wr_data       = in_rec;
    rd_en         = 1'b0;
    rd_addr       = head_r;
    push          = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_ch.action)
            ACT_ENQ: begin
              push.valid = 1'b1;
              push.res.last = 1'b1;
              if (held_r == FULL_CNT) begin
                push.res.status     = ST_FULL;
                push.res.fill_count = FILL_W'(held_r);
              end else begin
                wr_en               = 1'b1;
                tail_nxt            = ring_next(tail_r);
                held_nxt            = held_r + 1'b1;
                push.res.rec        = in_rec;
                push.res.status     = ST_OK;
                push.res.fill_count = FILL_W'(held_nxt);
              end
            end
            ACT_DEQ: begin
              if (held_r == '0) begin
                push.valid         = 1'b1;
                push.res.status    = ST_EMPTY;
                push.res.last      = 1'b1;
                push.res.is_empty  = 1'b1;
              end else begin
                rd_en     = 1'b1;
                head_nxt  = ring_next(head_r);
                held_nxt  = held_r - 1'b1;
                state_nxt = S_DEQ;
              end
            end
            ACT_FIND_CODE, ACT_FIND_HOURS, ACT_LIST: begin
              if (held_r == '0) begin
                push.valid         = 1'b1;
                push.res.status    = ST_EMPTY;
                push.res.last      = 1'b1;
                push.res.is_empty  = 1'b1;
              end else begin
                rd_en         = 1'b1;
                walk_nxt      = head_r;
                rem_nxt       = held_r;
                act_nxt       = in_ch.action;
                key_code_nxt  = in_ch.entry_code;
                key_hours_nxt = in_ch.entry_hours;
                pend_v_nxt    = 1'b0;
                state_nxt     = S_CMP;
              end
            end
            ACT_CLEAR: begin
              head_nxt          = '0;
              tail_nxt          = '0;
              held_nxt          = '0;
              push.valid        = 1'b1;
              push.res.status   = ST_EMPTY;
              push.res.last     = 1'b1;
              push.res.is_empty = 1'b1;
            end
            default: begin
              // unused codes: drop the beat
            end
          endcase
        end
      end

      S_DEQ: begin
        if (push_room) begin
          push.valid          = 1'b1;
          push.res.rec        = rd_data;
          push.res.status     = ST_OK;
          push.res.last       = 1'b1;
          push.res.is_empty   = (held_r == '0);
          push.res.fill_count = FILL_W'(held_r);
          state_nxt           = S_IDLE;
        end
      end

      S_CMP: begin
        if (go) begin
          if (need_push) begin
            push.valid          = 1'b1;
            push.res.rec        = pend_r;
            push.res.status     = ST_OK;
            push.res.is_empty   = (held_r == '0);
            push.res.fill_count = FILL_W'(held_r);
          end
          if (hit) begin
            pend_nxt   = rd_data;
            pend_v_nxt = 1'b1;
          end
          walk_nxt = walk_next_idx;
          rem_nxt  = rem_r - 1'b1;
          if (rem_r == CNT_W'(1)) begin
            state_nxt = S_FIN;
          end else begin
            rd_en   = 1'b1;
            rd_addr = walk_next_idx;
          end
        end
      end

      S_FIN: begin
        if (push_room) begin
          push.valid          = 1'b1;
          push.res.last       = 1'b1;
          push.res.is_empty   = (held_r == '0);
          push.res.fill_count = FILL_W'(held_r);
          if (pend_v_r) begin
            push.res.rec    = pend_r;
            push.res.status = ST_OK;
          end else begin
            push.res.status = ST_NOMATCH;
          end
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      head_r   <= '0;
      tail_r   <= '0;
      held_r   <= '0;
      pend_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      held_r   <= held_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    walk_r      <= walk_nxt;
    rem_r       <= rem_nxt;
    act_r       <= act_nxt;
    key_code_r  <= key_code_nxt;
    key_hours_r <= key_hours_nxt;
    pend_r      <= pend_nxt;
  end

endmodule

// File: rtl/searchable_record_fifo.sv
// Top level of the searchable record FIFO: ring of records in one memory with search walk.
// Depends on srf_pkg, srf_if, srf_mem, srf_obuf and srf_ctrl.
//
//  channel | direction | beat carries
//  --------+-----------+-------------------------------------------------------------
//  in_ch   | in        | action, entry_code, entry_hours, entry_tag
//  out_ch  | out       | out_code, out_hours, out_tag, status, last, is_empty, fill_count
//
// Enqueue, clear and any action on an empty queue are answered from the idle state; dequeue
// answers from the dequeue state after a registered read. A search or list walks the record store
// one entry per cycle through its single read port, while the result buffer has room.
// Reset clears the ring pointers and count; the record store itself is not cleared.
// A stalled result channel holds the walk once the two-entry result buffer fills.
module searchable_record_fifo import srf_pkg::*; #(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  srf_in_if.sink    in_ch,
  srf_out_if.source out_ch
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  rec_t             wr_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  rec_t             rd_data;
  push_t            push;
  logic             push_room;

  srf_ctrl #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .push      (push),
    .push_room (push_room)
  );

  srf_mem #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  srf_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_room (push_room),
    .out_ch    (out_ch)
  );

  // The sequencer never pushes into a full result buffer
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> push_room)
    else $error("result pushed with no buffer room");

  // Results without a record carry a zero payload
  a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.status != ST_OK) |->
      (out_ch.out_code == '0) && (out_ch.out_hours == '0) && (out_ch.out_tag == '0))
    else $error("non-record result with nonzero payload");

  // A full report is a single result at the full count
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.status == ST_FULL) |->
      out_ch.last && (out_ch.fill_count == FILL_W'(QUEUE_DEPTH)))
    else $error("full result with wrong count or last mark");

  // Empty flag and count agree while the count cannot wrap
  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (QUEUE_DEPTH < 64) |-> (out_ch.is_empty == (out_ch.fill_count == '0)))
    else $error("empty flag disagrees with fill count");

endmodule

// File: dv/srf_result_checker.sv
// Result checker for the searchable record FIFO: watches both channels, keeps its own
// ring of records and compares every result beat with the oldest predicted one.
// Depends on srf_pkg and the channel interfaces in srf_if.
module srf_result_checker import srf_pkg::*; #(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  srf_in_if    in_ch,
  srf_out_if   out_ch,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  rec_t        ring [QUEUE_DEPTH];
  int unsigned head_pos;
  int unsigned tail_pos;
  int unsigned held;
  res_t        predicted_results [$];

  function automatic string show(input res_t r);
    return $sformatf("code=%0d hours=%08h tag=%08h status=%0d last=%0b empty=%0b fill=%0d",
                     r.rec.code, r.rec.hours, r.rec.tag, r.status, r.last, r.is_empty,
                     r.fill_count);
  endfunction

  // Apply one action to the shadow ring and queue the results it should cause.
  task automatic apply_action(input logic [ACT_W-1:0] act, input rec_t key);
    res_t        batch [$];
    res_t        r;
    int unsigned idx;
    logic        hit;
    r = '0;
    case (act)
      ACT_ENQ: begin
        if (held >= QUEUE_DEPTH) begin
          r.status = ST_FULL;
          batch.push_back(r);
        end else begin
          ring[tail_pos] = key;
          tail_pos = (tail_pos + 1) % QUEUE_DEPTH;
          held++;
          r.rec = key;
          r.status = ST_OK;
          batch.push_back(r);
        end
      end
      ACT_DEQ: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.rec = ring[head_pos];
          r.status = ST_OK;
          head_pos = (head_pos + 1) % QUEUE_DEPTH;
          held--;
        end
        batch.push_back(r);
      end
      ACT_FIND_CODE, ACT_FIND_HOURS, ACT_LIST: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
          batch.push_back(r);
        end else begin
          idx = head_pos;
          for (int unsigned c = 0; c < held; c++) begin
            if (act == ACT_FIND_CODE)       hit = (ring[idx].code == key.code);
            else if (act == ACT_FIND_HOURS) hit = (ring[idx].hours == key.hours);
            else                            hit = 1'b1;
            if (hit) begin
              r.rec = ring[idx];
              r.status = ST_OK;
              batch.push_back(r);
            end
            idx = (idx + 1) % QUEUE_DEPTH;
          end
          if (batch.size() == 0) begin
            r.status = ST_NOMATCH;
            batch.push_back(r);
          end
        end
      end
      ACT_CLEAR: begin
        head_pos = 0;
        tail_pos = 0;
        held = 0;
        r.status = ST_EMPTY;
        batch.push_back(r);
      end
      default: return;
    endcase
    foreach (batch[k]) begin
      batch[k].last = (k == batch.size() - 1);
      batch[k].is_empty = (held == 0);
      batch[k].fill_count = FILL_W'(held);
      predicted_results.push_back(batch[k]);
    end
  endtask

  always @(posedge clk) begin
    rec_t key;
    res_t got;
    res_t want;
    if (!rst_n) begin
      head_pos = 0;
      tail_pos = 0;
      held = 0;
      predicted_results.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      // take the input beat first so a same-edge result still finds its prediction
      if (in_ch.valid && in_ch.ready) begin
        key.code = in_ch.entry_code;
        key.hours = in_ch.entry_hours;
        key.tag = in_ch.entry_tag;
        apply_action(in_ch.action, key);
      end
      if (out_ch.valid && out_ch.ready) begin
        got.rec.code = out_ch.out_code;
        got.rec.hours = out_ch.out_hours;
        got.rec.tag = out_ch.out_tag;
        got.status = out_ch.status;
        got.last = out_ch.last;
        got.is_empty = out_ch.is_empty;
        got.fill_count = out_ch.fill_count;
        if (predicted_results.size() == 0) begin
          $display("%0t: unexpected result beat: expected none, actual %s", $time, show(got));
          fail_count <= fail_count + 1;
        end else begin
          want = predicted_results.pop_front();
          if (got !== want) begin
            $display("%0t: result mismatch: expected %s, actual %s", $time, show(want),
                     show(got));
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= predicted_results.size();
    end
  end

endmodule

// File: dv/searchable_record_fifo_test.sv
// Top of the searchable record FIFO testbench: clock, reset, action beats and receiver
// stalls, with the verdict. Depends on srf_pkg, srf_if, the block and srf_result_checker.
module searchable_record_fifo_test import srf_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUEUE_DEPTH = 32;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASE_BEATS = 100;
  localparam int DRAIN_CYCLES = 2 * QUEUE_DEPTH + 8;
  // action codes the block ignores
  localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;

  localparam logic signed [31:0] CODE_POOL [6] = '{32'sd0, -32'sd1, 32'sh7fffffff,
                                                   32'sh80000000, 32'sd1, 32'sh1234};
  // +0, -0, 1.0, +inf, quiet NaN, all ones
  localparam logic [31:0] HOURS_POOL [6] = '{32'h0, 32'h80000000, 32'h3f800000,
                                             32'h7f800000, 32'h7fc00000, 32'hffffffff};

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   cycle_count = 0;
  int   gap_pct = 0;
  int   stall_pct = 0;

  srf_in_if  in_ch ();
  srf_out_if out_ch ();

  searchable_record_fifo #(.QUEUE_DEPTH(QUEUE_DEPTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  srf_result_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) results_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic signed [31:0] pick_code();
    if ($urandom_range(99) < 60) return CODE_POOL[$urandom_range(5)];
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_hours();
    if ($urandom_range(99) < 60) return HOURS_POOL[$urandom_range(5)];
    return $urandom;
  endfunction

  // Fill spells lean on enqueue to reach a full ring; drain spells lean on dequeue.
  function automatic logic [ACT_W-1:0] pick_action(input bit filling);
    int unsigned r;
    r = $urandom_range(99);
    if (r < (filling ? 78 : 15)) return ACT_ENQ;
    if (r < (filling ? 82 : 65)) return ACT_DEQ;
    if (r < (filling ? 88 : 75)) return ACT_FIND_CODE;
    if (r < (filling ? 93 : 85)) return ACT_FIND_HOURS;
    if (r < (filling ? 96 : 93)) return ACT_LIST;
    if (r < (filling ? 97 : 96)) return ACT_CLEAR;
    return r[0] ? ACT_SPARE_LO : ACT_SPARE_HI;
  endfunction

  task automatic send_beat(input logic [ACT_W-1:0] act, input logic signed [31:0] code,
                           input logic [31:0] hours, input logic [31:0] tag);
    while ($urandom_range(99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.entry_code <= code;
    in_ch.entry_hours <= hours;
    in_ch.entry_tag <= tag;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  initial begin
    logic [ACT_W-1:0] act;
    int               counted;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.action <= ACT_ENQ;
    in_ch.entry_code <= '0;
    in_ch.entry_hours <= '0;
    in_ch.entry_tag <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty ring: every walk and a dequeue report empty
    send_beat(ACT_DEQ, 32'sd5, 32'h1, 32'h2);
    send_beat(ACT_FIND_CODE, 32'sd0, 32'h0, 32'h0);
    send_beat(ACT_FIND_HOURS, 32'sd0, 32'h0, 32'h0);
    send_beat(ACT_LIST, 32'sd0, 32'h0, 32'h0);
    // field extremes
    send_beat(ACT_ENQ, 32'sh7fffffff, 32'hffffffff, 32'h0);
    send_beat(ACT_ENQ, 32'sh80000000, 32'h0, 32'hffffffff);
    send_beat(ACT_ENQ, -32'sd1, 32'h3f800000, 32'ha5a5a5a5);
    send_beat(ACT_ENQ, 32'sd0, 32'h80000000, 32'h5a5a5a5a);
    send_beat(ACT_FIND_CODE, 32'sh80000000, 32'h0, 32'h0);
    send_beat(ACT_FIND_CODE, 32'sd12345, 32'h0, 32'h0);
    send_beat(ACT_FIND_HOURS, 32'sd0, 32'h3f800000, 32'h0);
    // +0 and -0 differ as patterns
    send_beat(ACT_FIND_HOURS, 32'sd0, 32'h0, 32'h0);
    send_beat(ACT_FIND_HOURS, 32'sd0, 32'h7fc00000, 32'h0);
    send_beat(ACT_LIST, 32'sd0, 32'h0, 32'h0);
    send_beat(ACT_ENQ, -32'sd1, 32'h3f800000, 32'h0f0f0f0f);
    send_beat(ACT_FIND_CODE, -32'sd1, 32'h0, 32'h0);
    send_beat(ACT_SPARE_LO, 32'sd1, 32'h1, 32'h1);
    send_beat(ACT_SPARE_HI, -32'sd1, 32'hffffffff, 32'hffffffff);
    send_beat(ACT_DEQ, 32'sd0, 32'h0, 32'h0);
    send_beat(ACT_CLEAR, 32'sd0, 32'h0, 32'h0);
    send_beat(ACT_LIST, 32'sd0, 32'h0, 32'h0);
    send_beat(ACT_DEQ, 32'sd0, 32'h0, 32'h0);
    send_beat(ACT_ENQ, 32'sd77, 32'h41200000, 32'hdeadbeef);
    send_beat(ACT_LIST, 32'sd0, 32'h0, 32'h0);

    // random beats: no idling, sender gaps, receiver stalls, then both lightly
    for (int ph = 0; ph < 4; ph++) begin
      gap_pct = (ph == 1) ? 74 : (ph == 3) ? 10 : 0;
      stall_pct = (ph == 2) ? 74 : (ph == 3) ? 10 : 0;
      counted = 0;
      while (counted < PHASE_BEATS) begin
        act = pick_action(((counted / 48) % 2) == 0);
        send_beat(act, pick_code(), pick_hours(), $urandom);
        if (act <= ACT_CLEAR) counted++;
      end
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
